// ----- hw/rtl/ini_text_tokenizer_unit_macros.svh -----
// ----------------------------------------------------------------------------
// ini_text_tokenizer_unit_macros.svh
// Assertion macros used by the tokenizer checker.
// ----------------------------------------------------------------------------
`ifndef INI_TEXT_TOKENIZER_UNIT_MACROS_SVH
`define INI_TEXT_TOKENIZER_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TTI_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define TTI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/tti_pkg.sv -----
// ----------------------------------------------------------------------------
// tti_pkg
// Shared types, constants and character classes of the INI tokenizer.
// ----------------------------------------------------------------------------
package tti_pkg;

  localparam int MAX_TOKEN = 32;
  localparam int LEN_W     = $clog2(MAX_TOKEN + 1);
  localparam int ADDR_W    = $clog2(MAX_TOKEN);

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SECTION  = 3'd1;
  localparam logic [2:0] ST_KEY      = 3'd2;
  localparam logic [2:0] ST_KEY_SP   = 3'd3;
  localparam logic [2:0] ST_VALUE0   = 3'd4;
  localparam logic [2:0] ST_VALUE    = 3'd5;
  localparam logic [2:0] ST_VALUE_SP = 3'd6;
  localparam logic [2:0] ST_COMMENT  = 3'd7;

  localparam logic [1:0] EV_SECTION = 2'd0;
  localparam logic [1:0] EV_KEY     = 2'd1;
  localparam logic [1:0] EV_VALUE   = 2'd2;
  localparam logic [1:0] EV_ERROR   = 2'd3;

  localparam logic [1:0] EM_NONE  = 2'd0;
  localparam logic [1:0] EM_STORE = 2'd1;
  localparam logic [1:0] EM_EMPTY = 2'd2;

  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef struct packed {
    logic       clear_pre;
    logic       add;
    logic [7:0] data;
    logic [1:0] emit;
    logic [1:0] kind;
    logic       clear_post;
  } cmd_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

  function automatic logic is_break(input logic [7:0] c);
    return (c == CH_LF) || (c == CH_CR);
  endfunction

endpackage

// ----- hw/rtl/tti_front.sv -----
// ----------------------------------------------------------------------------
// tti_front
// Line recognizer: classifies each byte and issues one store command.
// ----------------------------------------------------------------------------
module tti_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic          mode,
  input  logic [7:0]    text_byte,
  input  logic          q_full,
  output logic          cmd_valid,
  output tti_pkg::cmd_t cmd
);
  import tti_pkg::*;

  logic [2:0] parse_state;
  logic [2:0] parse_state_next;
  logic       blank;
  logic       brk;
  logic       alnum;

  assign full      = q_full;
  assign cmd_valid = push && !q_full;
  assign blank     = is_blank(text_byte);
  assign brk       = is_break(text_byte);
  assign alnum     = is_alnum(text_byte);

  always_comb begin
    cmd              = '0;
    cmd.data         = text_byte;
    parse_state_next = parse_state;
    if (mode) begin
      case (parse_state)
        ST_SECTION, ST_KEY, ST_KEY_SP: begin
          cmd.emit = EM_EMPTY;
          cmd.kind = EV_ERROR;
        end
        ST_VALUE0: begin
          cmd.emit = EM_EMPTY;
          cmd.kind = EV_VALUE;
        end
        ST_VALUE, ST_VALUE_SP: begin
          cmd.emit = EM_STORE;
          cmd.kind = EV_VALUE;
        end
        default: ;
      endcase
      cmd.clear_post   = 1'b1;
      parse_state_next = ST_IDLE;
    end else begin
      case (parse_state)
        ST_IDLE: begin
          if (text_byte == CH_LBRACK) begin
            cmd.clear_pre    = 1'b1;
            parse_state_next = ST_SECTION;
          end else if (alnum) begin
            cmd.clear_pre    = 1'b1;
            cmd.add          = 1'b1;
            parse_state_next = ST_KEY;
          end else if (text_byte == CH_HASH) begin
            parse_state_next = ST_COMMENT;
          end else if (!blank) begin
            cmd.add  = 1'b1;
            cmd.emit = EM_STORE;
            cmd.kind = EV_ERROR;
          end
        end
        ST_SECTION: begin
          if (text_byte == CH_RBRACK) begin
            cmd.emit         = EM_STORE;
            cmd.kind         = EV_SECTION;
            cmd.clear_post   = 1'b1;
            parse_state_next = ST_IDLE;
          end else begin
            cmd.add = 1'b1;
          end
        end
        ST_KEY: begin
          if (text_byte == CH_EQUAL) begin
            cmd.emit         = EM_STORE;
            cmd.kind         = EV_KEY;
            parse_state_next = ST_VALUE0;
          end else if (blank) begin
            cmd.emit         = EM_STORE;
            cmd.kind         = EV_KEY;
            parse_state_next = ST_KEY_SP;
          end else begin
            cmd.add = 1'b1;
          end
        end
        ST_KEY_SP: begin
          if (text_byte == CH_EQUAL) begin
            parse_state_next = ST_VALUE0;
          end else if (!blank) begin
            cmd.add  = 1'b1;
            cmd.emit = EM_STORE;
            cmd.kind = EV_ERROR;
          end
        end
        ST_VALUE0: begin
          if (brk) begin
            cmd.emit         = EM_EMPTY;
            cmd.kind         = EV_VALUE;
            cmd.clear_post   = 1'b1;
            parse_state_next = ST_IDLE;
          end else if (!blank) begin
            cmd.clear_pre    = 1'b1;
            cmd.add          = 1'b1;
            parse_state_next = ST_VALUE;
          end
        end
        ST_VALUE: begin
          if (brk) begin
            cmd.emit         = EM_STORE;
            cmd.kind         = EV_VALUE;
            cmd.clear_post   = 1'b1;
            parse_state_next = ST_IDLE;
          end else if (blank) begin
            parse_state_next = ST_VALUE_SP;
          end else begin
            cmd.add = 1'b1;
          end
        end
        ST_VALUE_SP: begin
          if (brk) begin
            cmd.emit         = EM_STORE;
            cmd.kind         = EV_VALUE;
            cmd.clear_post   = 1'b1;
            parse_state_next = ST_IDLE;
          end else if (!blank) begin
            cmd.add  = 1'b1;
            cmd.emit = EM_STORE;
            cmd.kind = EV_ERROR;
          end
        end
        default: begin
          if (brk) begin
            cmd.clear_post   = 1'b1;
            parse_state_next = ST_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state <= ST_IDLE;
    end else if (cmd_valid) begin
      parse_state <= parse_state_next;
    end
  end

endmodule

// ----- hw/rtl/tti_cmdq.sv -----
// ----------------------------------------------------------------------------
// tti_cmdq
// Short command queue between the recognizer and the token engine.
// ----------------------------------------------------------------------------
module tti_cmdq (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  tti_pkg::cmd_t wr_cmd,
  output logic          q_full,
  input  logic          rd,
  output logic          q_empty,
  output tti_pkg::cmd_t rd_cmd
);
  import tti_pkg::*;

  cmd_t               entries [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr;
  logic [CMDQ_AW-1:0] rd_ptr;
  logic [CMDQ_AW:0]   count;
  logic               do_wr;
  logic               do_rd;

  assign q_full  = (count == (CMDQ_AW + 1)'(CMDQ_DEPTH));
  assign q_empty = (count == '0);
  assign rd_cmd  = entries[rd_ptr];
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hw/rtl/tti_back.sv -----
// ----------------------------------------------------------------------------
// tti_back
// Token engine: owns the token store, runs commands and emits token bytes.
// ----------------------------------------------------------------------------
module tti_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  tti_pkg::cmd_t cmd,
  output logic          cmd_rd,
  output logic          empty,
  input  logic          pop,
  output logic [1:0]    event_kind,
  output logic [7:0]    token_byte,
  output logic          byte_valid,
  output logic          last,
  output logic          truncated
);
  import tti_pkg::*;

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_RD    = 2'd1;
  localparam logic [1:0] B_WR    = 2'd2;
  localparam logic [1:0] B_EMPTY = 2'd3;

  logic [7:0]       mem [MAX_TOKEN];
  logic [1:0]       bstate;
  logic [LEN_W-1:0] len;
  logic             ovf;
  logic [LEN_W-1:0] idx;
  logic [LEN_W-1:0] idx_inc;
  logic [1:0]       kind;
  logic             post_clr;
  logic             empty_trunc;
  logic [7:0]       rd_data;
  logic             out_valid;
  logic             out_free;
  logic             at_last;
  logic             res_load;
  logic             clr_now;

  logic [LEN_W-1:0] len_a;
  logic             ovf_a;
  logic [LEN_W-1:0] len_b;
  logic             ovf_b;
  logic             wr_en;
  logic             rd_en;
  logic [ADDR_W-1:0] rd_addr;

  assign cmd_rd   = (bstate == B_IDLE) && !q_empty;
  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;
  assign idx_inc  = idx + LEN_W'(1);
  assign at_last  = (idx_inc == len);
  assign res_load = out_free && ((bstate == B_WR) || (bstate == B_EMPTY));
  assign clr_now  = (cmd.emit == EM_NONE) && cmd.clear_post;

  always_comb begin
    len_a = cmd.clear_pre ? '0 : len;
    ovf_a = cmd.clear_pre ? 1'b0 : ovf;
    len_b = len_a;
    ovf_b = ovf_a;
    wr_en = 1'b0;
    if (cmd.add) begin
      if (len_a < LEN_W'(MAX_TOKEN)) begin
        wr_en = cmd_rd;
        len_b = len_a + LEN_W'(1);
      end else begin
        ovf_b = 1'b1;
      end
    end
  end

  assign rd_en   = (bstate == B_RD) || ((bstate == B_WR) && out_free && !at_last);
  assign rd_addr = (bstate == B_RD) ? idx[ADDR_W-1:0] : idx_inc[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[len_a[ADDR_W-1:0]] <= cmd.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate    <= B_IDLE;
      len       <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
      post_clr  <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (bstate)
        B_IDLE: begin
          if (cmd_rd) begin
            kind     <= cmd.kind;
            post_clr <= cmd.clear_post;
            idx      <= '0;
            len      <= clr_now ? '0 : len_b;
            ovf      <= clr_now ? 1'b0 : ovf_b;
            case (cmd.emit)
              EM_STORE: begin
                if (len_b != '0) begin
                  bstate <= B_RD;
                end else begin
                  empty_trunc <= ovf_b;
                  bstate      <= B_EMPTY;
                end
              end
              EM_EMPTY: begin
                empty_trunc <= 1'b0;
                bstate      <= B_EMPTY;
              end
              default: ;
            endcase
          end
        end
        B_RD: begin
          bstate <= B_WR;
        end
        B_WR: begin
          if (out_free) begin
            event_kind <= kind;
            token_byte <= rd_data;
            byte_valid <= 1'b1;
            last       <= at_last;
            truncated  <= ovf;
            if (at_last) begin
              bstate <= B_IDLE;
              if (post_clr) begin
                len <= '0;
                ovf <= 1'b0;
              end
            end else begin
              idx <= idx_inc;
            end
          end
        end
        default: begin
          if (out_free) begin
            event_kind <= kind;
            token_byte <= '0;
            byte_valid <= 1'b0;
            last       <= 1'b1;
            truncated  <= empty_trunc;
            bstate     <= B_IDLE;
            if (post_clr) begin
              len <= '0;
              ovf <= 1'b0;
            end
          end
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/ini_text_tokenizer_unit.sv -----
// ----------------------------------------------------------------------------
// ini_text_tokenizer_unit
// Byte-serial INI tokenizer with queue-style input and result ports.
// ----------------------------------------------------------------------------
// Each accepted request is one text byte or an end-of-input mark. The front
// recognizer takes one request per cycle unless the queue is full and turns it
// into a store command; a four-entry command queue decouples it from the token
// engine. The engine takes a command whenever it is idle and, for a completed
// token, reads the token store in its read state and then streams the store out
// at one byte per cycle while the result is taken. It takes no new command while
// it streams a token, so throughput is set by the engine and its one result
// register.
module ini_text_tokenizer_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       mode,
  input  logic [7:0] text_byte,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] event_kind,
  output logic [7:0] token_byte,
  output logic       byte_valid,
  output logic       last,
  output logic       truncated
);
  import tti_pkg::*;

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic front_valid;
  logic q_full;
  logic q_empty;
  logic back_rd;

  tti_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .mode      (mode),
    .text_byte (text_byte),
    .q_full    (q_full),
    .cmd_valid (front_valid),
    .cmd       (front_cmd)
  );

  tti_cmdq u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr      (front_valid),
    .wr_cmd  (front_cmd),
    .q_full  (q_full),
    .rd      (back_rd),
    .q_empty (q_empty),
    .rd_cmd  (back_cmd)
  );

  tti_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .cmd        (back_cmd),
    .cmd_rd     (back_rd),
    .empty      (empty),
    .pop        (pop),
    .event_kind (event_kind),
    .token_byte (token_byte),
    .byte_valid (byte_valid),
    .last       (last),
    .truncated  (truncated)
  );

endmodule

// ----- hw/rtl/tti_checker.sv -----
// ----------------------------------------------------------------------------
// tti_checker
// Port-level checks of the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "ini_text_tokenizer_unit_macros.svh"

module tti_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [1:0] event_kind,
  input logic [7:0] token_byte,
  input logic       byte_valid,
  input logic       last,
  input logic       truncated
);

  `TTI_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> (empty && !full),
                     "queues not clear after reset")

  `TTI_ASSERT(a_hold_result, clk, rst,
              (!empty && !pop) |=> (!empty && $stable(token_byte) &&
                                    $stable(event_kind) && $stable(last)),
              "stalled result changed")

  `TTI_ASSERT(a_empty_token_last, clk, rst,
              (!empty && !byte_valid) |-> (last && token_byte == 8'h00),
              "empty token not a single zero result")

  `TTI_ASSERT(a_empty_token_trunc, clk, rst,
              (!empty && !byte_valid) |-> (!truncated),
              "empty token flagged as truncated")

endmodule

bind ini_text_tokenizer_unit tti_checker u_tti_checker (
  .clk        (clk),
  .rst        (rst),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .event_kind (event_kind),
  .token_byte (token_byte),
  .byte_valid (byte_valid),
  .last       (last),
  .truncated  (truncated)
);
